// File: rtl/stt_pkg.sv
// shared types, token kind codes and the keyword table for the source tokenizer
// no dependencies
package stt_pkg;

    localparam int POS_BITS_DEF    = 32;
    localparam int KEYWORD_MAX_DEF = 10;
    localparam int KW_COUNT        = 21;
    localparam int KW_CHARS        = 10;
    localparam int QDEPTH          = 4;

    typedef logic [6:0] t_kind;

    localparam t_kind K_IDENT  = 7'd21;
    localparam t_kind K_NUMBER = 7'd22;
    localparam t_kind K_STRING = 7'd23;
    localparam t_kind K_CHAR   = 7'd24;
    localparam t_kind K_END    = 7'd25;
    localparam t_kind K_LPAREN = 7'd26;
    localparam t_kind K_RPAREN = 7'd27;
    localparam t_kind K_LBRACE = 7'd28;
    localparam t_kind K_RBRACE = 7'd29;
    localparam t_kind K_LBRACK = 7'd30;
    localparam t_kind K_RBRACK = 7'd31;
    localparam t_kind K_SEMI   = 7'd32;
    localparam t_kind K_DOT    = 7'd33;
    localparam t_kind K_COMMA  = 7'd34;
    localparam t_kind K_HASH   = 7'd35;
    localparam t_kind K_DOLLAR = 7'd36;
    localparam t_kind K_AT     = 7'd37;
    localparam t_kind K_QUEST  = 7'd38;
    localparam t_kind K_DCOLON = 7'd39;
    localparam t_kind K_ERROR  = 7'd85;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] offset;
        logic [31:0] span_len;
        logic        last;
    } t_tok;

    localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
        "module", "include", "fn", "constraint", "return", "struct", "union",
        "defer", "match", "enum", "type", "mut", "if", "else", "for", "while",
        "break", "continue", "true", "false", "null"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd6, 4'd7, 4'd2, 4'd10, 4'd6, 4'd6, 4'd5, 4'd5, 4'd5, 4'd4, 4'd4,
        4'd3, 4'd2, 4'd4, 4'd3, 4'd5, 4'd5, 4'd8, 4'd4, 4'd5, 4'd4
    };

    // word holds the first bytes of the identifier, first byte in the top byte
    function automatic t_kind kw_lookup(input logic [8*KW_CHARS-1:0] word,
                                        input logic [4:0] len);
        t_kind res;
        logic  hit;
        res = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            hit = ({1'b0, KW_LEN[i]} == len);
            for (int j = 0; j < KW_CHARS; j++) begin
                if (j < int'(KW_LEN[i])) begin
                    if (word[8*(KW_CHARS-1-j) +: 8] !=
                        KW_TEXT[i][8*(int'(KW_LEN[i])-1-j) +: 8]) begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit) begin
                res = t_kind'(i);
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/source_text_tokenizer_core.sv
// Streaming source tokenizer, top level: lexer plus output token queue.
// Depends on stt_pkg, stt_lexer, stt_outq.
//
// Input channel: i_valid/o_stall with i_op and i_ch. i_op = 0 carries one
// source byte, i_op = 1 marks end of source: the pending token is flushed and
// an end token follows, after which lexing starts again at the same position.
// Output channel: o_valid/i_stall with o_kind, o_offset, o_span_len, o_last.
// o_last marks the final token caused by one input word.
// Throughput: one byte per cycle while o_stall is low; the lexer transition is
// combinational logic. Each word makes zero, one or two tokens, which enter a four-entry
// queue; the queue registers them at the clock edge that takes the word.
// When the receiver stalls, tokens wait in the queue and input is still taken
// while at least two entries are free; o_stall rises only when fewer are.
// Tokens leave in order, one per cycle while the receiver does not stall.
// Reset (synchronous, active low) returns the lexer to idle at position zero
// and empties the queue.
module source_text_tokenizer_core #(
    parameter int POS_BITS    = stt_pkg::POS_BITS_DEF,
    parameter int KEYWORD_MAX = stt_pkg::KEYWORD_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_op,
    input  logic [7:0]          i_ch,
    output logic                o_valid,
    input  logic                i_stall,
    output stt_pkg::t_kind      o_kind,
    output logic [31:0]         o_offset,
    output logic [31:0]         o_span_len,
    output logic                o_last
);
    import stt_pkg::*;

    logic       acc, room, pop;
    logic [1:0] cnt;
    logic [2:0] fill;
    t_tok       res0, res1, head;

    assign o_stall = !room;
    assign acc     = i_valid && room;
    assign pop     = o_valid && !i_stall;

    stt_lexer #(
        .POS_BITS    (POS_BITS),
        .KEYWORD_MAX (KEYWORD_MAX)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_op    (i_op),
        .i_ch    (i_ch),
        .o_count (cnt),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    stt_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (acc ? cnt : 2'd0),
        .i_res0   (res0),
        .i_res1   (res1),
        .i_pop    (pop),
        .o_room   (room),
        .o_valid  (o_valid),
        .o_tok    (head),
        .o_fill   (fill)
    );

    assign o_kind     = head.kind;
    assign o_offset   = head.offset;
    assign o_span_len = head.span_len;
    assign o_last     = head.last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill <= 3'(QDEPTH))
        else $error("token queue overflow");

    a_end_gives_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_op) |=> o_valid)
        else $error("end of source produced no token");

    a_end_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_op) |-> (cnt != 2'd0))
        else $error("end of source word made no result");

endmodule

// File: rtl/stt_lexer.sv
// lexer state machine: mode, token start, position and identifier buffer
// produces up to two tokens per accepted word; uses stt_pkg
module stt_lexer #(
    parameter int POS_BITS    = stt_pkg::POS_BITS_DEF,
    parameter int KEYWORD_MAX = stt_pkg::KEYWORD_MAX_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc,
    input  logic          i_op,
    input  logic [7:0]    i_ch,
    output logic [1:0]    o_count,
    output stt_pkg::t_tok o_res0,
    output stt_pkg::t_tok o_res1
);
    import stt_pkg::*;

    localparam int KIDX = $clog2(KEYWORD_MAX);

    typedef enum logic [5:0] {
        M_IDLE, M_IDENT, M_NZERO, M_NINT, M_NFRAC, M_NEXP0, M_NEXP, M_NHEX,
        M_STR, M_STR_ESC, M_CHR, M_CHR_ESC,
        M_COLON, M_LT, M_SHL, M_GT, M_SHR,
        M_BANG, M_BANG_AMP, M_BANG_PIPE, M_BANG_CARET,
        M_TILDE, M_TILDE_AMP, M_TILDE_PIPE, M_TILDE_CARET,
        M_PLUS, M_MINUS, M_STAR, M_SLASH, M_PERCENT, M_CARET,
        M_AMP, M_AMP2, M_PIPE, M_PIPE2
    } t_mode;

    t_mode               r_mode, n_mode;
    logic [POS_BITS-1:0] r_start, n_start;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [7:0]          r_buf [KEYWORD_MAX];
    logic                buf_we;
    logic [KIDX-1:0]     buf_idx;

    logic [POS_BITS-1:0]   len;
    logic [8*KW_CHARS-1:0] word;
    t_kind                 id_kind, pend_kind, stop_kind, eq_kind;
    logic                  has_eq;
    logic                  is_dig, is_alpha, is_hex, dg, ex, absorbed;
    logic                  fv, sv;
    t_kind                 fk, sk;
    logic [POS_BITS-1:0]   fo, fl, so, sl;

    function automatic logic [31:0] to32(input logic [POS_BITS-1:0] v);
        return 32'(64'(v));
    endfunction

    always_comb begin
        for (int j = 0; j < KW_CHARS; j++) begin
            word[8*(KW_CHARS-1-j) +: 8] = r_buf[j];
        end
    end

    assign len = r_pos - r_start;

    always_comb begin
        if (len == '0 || len > POS_BITS'(KEYWORD_MAX) || len > POS_BITS'(KW_CHARS)) begin
            id_kind = K_IDENT;
        end else begin
            id_kind = kw_lookup(word, len[4:0]);
        end
    end

    // operator modes: kind when the token stops, kind when '=' follows
    always_comb begin
        has_eq    = 1'b1;
        eq_kind   = K_ERROR;
        stop_kind = K_ERROR;
        case (r_mode)
            M_COLON:       begin stop_kind = 7'd40; has_eq = 1'b0; end
            M_LT:          begin stop_kind = 7'd44; eq_kind = 7'd41; end
            M_SHL:         begin stop_kind = 7'd43; eq_kind = 7'd42; end
            M_GT:          begin stop_kind = 7'd48; eq_kind = 7'd45; end
            M_SHR:         begin stop_kind = 7'd47; eq_kind = 7'd46; end
            M_BANG:        begin stop_kind = 7'd56; eq_kind = 7'd49; end
            M_BANG_AMP:    begin stop_kind = 7'd51; eq_kind = 7'd50; end
            M_BANG_PIPE:   begin stop_kind = 7'd53; eq_kind = 7'd52; end
            M_BANG_CARET:  begin stop_kind = 7'd55; eq_kind = 7'd54; end
            M_TILDE:       begin stop_kind = 7'd64; eq_kind = 7'd57; end
            M_TILDE_AMP:   begin stop_kind = 7'd59; eq_kind = 7'd58; end
            M_TILDE_PIPE:  begin stop_kind = 7'd61; eq_kind = 7'd60; end
            M_TILDE_CARET: begin stop_kind = 7'd63; eq_kind = 7'd62; end
            M_PLUS:        begin stop_kind = 7'd66; eq_kind = 7'd65; end
            M_MINUS:       begin stop_kind = 7'd68; eq_kind = 7'd67; end
            M_STAR:        begin stop_kind = 7'd70; eq_kind = 7'd69; end
            M_SLASH:       begin stop_kind = 7'd72; eq_kind = 7'd71; end
            M_PERCENT:     begin stop_kind = 7'd74; eq_kind = 7'd73; end
            M_CARET:       begin stop_kind = 7'd84; eq_kind = 7'd83; end
            M_AMP:         begin stop_kind = 7'd78; eq_kind = 7'd77; end
            M_AMP2:        begin stop_kind = 7'd76; eq_kind = 7'd75; end
            M_PIPE:        begin stop_kind = 7'd82; eq_kind = 7'd81; end
            M_PIPE2:       begin stop_kind = 7'd80; eq_kind = 7'd79; end
            default:       has_eq = 1'b0;
        endcase
    end

    always_comb begin
        case (r_mode)
            M_IDENT:                                         pend_kind = id_kind;
            M_NZERO, M_NINT, M_NFRAC, M_NEXP0, M_NEXP, M_NHEX: pend_kind = K_NUMBER;
            M_STR, M_STR_ESC:                                pend_kind = K_STRING;
            M_CHR, M_CHR_ESC:                                pend_kind = K_CHAR;
            default:                                         pend_kind = stop_kind;
        endcase
    end

    assign is_dig   = (i_ch >= "0") && (i_ch <= "9");
    assign is_alpha = ((i_ch >= "a") && (i_ch <= "z")) || ((i_ch >= "A") && (i_ch <= "Z"))
                      || (i_ch == "_");
    assign is_hex   = is_dig || ((i_ch >= "a") && (i_ch <= "f"))
                      || ((i_ch >= "A") && (i_ch <= "F"));
    assign dg       = is_dig || (i_ch == "_");
    assign ex       = (i_ch == "e") || (i_ch == "E");

    always_comb begin
        n_mode   = r_mode;
        n_start  = r_start;
        n_pos    = r_pos;
        buf_we   = 1'b0;
        buf_idx  = len[KIDX-1:0];
        absorbed = 1'b0;
        fv = 1'b0; fk = pend_kind; fo = r_start; fl = len;
        sv = 1'b0; sk = K_END;     so = r_pos;   sl = '0;
        if (i_op) begin
            if (r_mode != M_IDLE) begin
                fv = 1'b1;
            end
            sv     = 1'b1;
            n_mode = M_IDLE;
        end else begin
            n_pos = r_pos + 1'b1;
            unique case (r_mode)
                M_IDLE: ;
                M_IDENT: begin
                    if (is_alpha || is_dig) begin
                        absorbed = 1'b1;
                        buf_we   = (len < POS_BITS'(KEYWORD_MAX));
                    end
                end
                M_NZERO, M_NINT: begin
                    if (r_mode == M_NZERO && (i_ch == "x" || i_ch == "X" || i_ch == "b"
                        || i_ch == "B" || i_ch == "o" || i_ch == "O")) begin
                        absorbed = 1'b1; n_mode = M_NHEX;
                    end else if (dg) begin
                        absorbed = 1'b1; n_mode = M_NINT;
                    end else if (i_ch == ".") begin
                        absorbed = 1'b1; n_mode = M_NFRAC;
                    end else if (ex) begin
                        absorbed = 1'b1; n_mode = M_NEXP0;
                    end
                end
                M_NFRAC: begin
                    if (dg) begin
                        absorbed = 1'b1;
                    end else if (ex) begin
                        absorbed = 1'b1; n_mode = M_NEXP0;
                    end
                end
                M_NEXP0: begin
                    if (dg || i_ch == "+" || i_ch == "-") begin
                        absorbed = 1'b1; n_mode = M_NEXP;
                    end
                end
                M_NEXP:  absorbed = dg;
                M_NHEX:  absorbed = is_hex || (i_ch == "_");
                M_STR, M_CHR: begin
                    absorbed = 1'b1;
                    if ((r_mode == M_STR && i_ch == "\"") || (r_mode == M_CHR && i_ch == "'")) begin
                        fv = 1'b1; fl = len + 1'b1; n_mode = M_IDLE;
                    end else if (i_ch == "\\") begin
                        n_mode = (r_mode == M_STR) ? M_STR_ESC : M_CHR_ESC;
                    end
                end
                M_STR_ESC: begin absorbed = 1'b1; n_mode = M_STR; end
                M_CHR_ESC: begin absorbed = 1'b1; n_mode = M_CHR; end
                default: begin
                    absorbed = 1'b1;
                    if (i_ch == "=" && has_eq) begin
                        fv = 1'b1; fk = eq_kind; fl = len + 1'b1; n_mode = M_IDLE;
                    end else if (r_mode == M_COLON && i_ch == ":") begin
                        fv = 1'b1; fk = K_DCOLON; fl = len + 1'b1; n_mode = M_IDLE;
                    end else if (r_mode == M_LT && i_ch == "<") begin
                        n_mode = M_SHL;
                    end else if (r_mode == M_GT && i_ch == ">") begin
                        n_mode = M_SHR;
                    end else if ((r_mode == M_BANG || r_mode == M_TILDE) && i_ch == "&") begin
                        n_mode = (r_mode == M_BANG) ? M_BANG_AMP : M_TILDE_AMP;
                    end else if ((r_mode == M_BANG || r_mode == M_TILDE) && i_ch == "|") begin
                        n_mode = (r_mode == M_BANG) ? M_BANG_PIPE : M_TILDE_PIPE;
                    end else if ((r_mode == M_BANG || r_mode == M_TILDE) && i_ch == "^") begin
                        n_mode = (r_mode == M_BANG) ? M_BANG_CARET : M_TILDE_CARET;
                    end else if (r_mode == M_AMP && i_ch == "&") begin
                        n_mode = M_AMP2;
                    end else if (r_mode == M_PIPE && i_ch == "|") begin
                        n_mode = M_PIPE2;
                    end else begin
                        absorbed = 1'b0;
                    end
                end
            endcase
            if (!absorbed) begin
                if (r_mode != M_IDLE) begin
                    fv     = 1'b1;
                    n_mode = M_IDLE;
                end
                if (!(i_ch == " " || i_ch == "\t" || i_ch == "\n" || i_ch == "\r")) begin
                    n_start = r_pos;
                    so      = r_pos;
                    sl      = POS_BITS'(1);
                    if (is_dig) begin
                        n_mode = (i_ch == "0") ? M_NZERO : M_NINT;
                    end else if (is_alpha) begin
                        n_mode  = M_IDENT;
                        buf_we  = 1'b1;
                        buf_idx = '0;
                    end else begin
                        case (i_ch)
                            "(":  begin sv = 1'b1; sk = K_LPAREN; end
                            ")":  begin sv = 1'b1; sk = K_RPAREN; end
                            "{":  begin sv = 1'b1; sk = K_LBRACE; end
                            "}":  begin sv = 1'b1; sk = K_RBRACE; end
                            "[":  begin sv = 1'b1; sk = K_LBRACK; end
                            "]":  begin sv = 1'b1; sk = K_RBRACK; end
                            ";":  begin sv = 1'b1; sk = K_SEMI;   end
                            ".":  begin sv = 1'b1; sk = K_DOT;    end
                            ",":  begin sv = 1'b1; sk = K_COMMA;  end
                            "#":  begin sv = 1'b1; sk = K_HASH;   end
                            "$":  begin sv = 1'b1; sk = K_DOLLAR; end
                            "@":  begin sv = 1'b1; sk = K_AT;     end
                            "?":  begin sv = 1'b1; sk = K_QUEST;  end
                            "'":  n_mode = M_CHR;
                            "\"": n_mode = M_STR;
                            ":":  n_mode = M_COLON;
                            "<":  n_mode = M_LT;
                            ">":  n_mode = M_GT;
                            "!":  n_mode = M_BANG;
                            "~":  n_mode = M_TILDE;
                            "+":  n_mode = M_PLUS;
                            "-":  n_mode = M_MINUS;
                            "*":  n_mode = M_STAR;
                            "/":  n_mode = M_SLASH;
                            "%":  n_mode = M_PERCENT;
                            "&":  n_mode = M_AMP;
                            "|":  n_mode = M_PIPE;
                            "^":  n_mode = M_CARET;
                            default: begin sv = 1'b1; sk = K_ERROR; end
                        endcase
                    end
                end
            end
        end
    end

    // pack the flushed token and the new one in order
    always_comb begin
        o_res0 = '{kind: fk, offset: to32(fo), span_len: to32(fl), last: !sv};
        o_res1 = '{kind: sk, offset: to32(so), span_len: to32(sl), last: 1'b1};
        if (!fv) begin
            o_res0 = o_res1;
        end
        o_count = {1'b0, fv} + {1'b0, sv};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_start <= '0;
            r_pos   <= '0;
        end else if (i_acc) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc && buf_we) begin
            r_buf[buf_idx] <= i_ch;
        end
    end

endmodule

// File: rtl/stt_outq.sv
// four-entry token queue between the lexer and the output port
// takes up to two tokens a cycle, gives one; uses stt_pkg
module stt_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_push_n,
    input  stt_pkg::t_tok i_res0,
    input  stt_pkg::t_tok i_res1,
    input  logic          i_pop,
    output logic          o_room,
    output logic          o_valid,
    output stt_pkg::t_tok o_tok,
    output logic [2:0]    o_fill
);
    import stt_pkg::*;

    localparam int QW = $clog2(QDEPTH);

    t_tok          r_mem [QDEPTH];
    logic [QW-1:0] r_head, r_tail;
    logic [QW:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_head];
    assign o_room  = (r_cnt <= (QW+1)'(QDEPTH - 2));
    assign o_fill  = 3'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_tail] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_tail + 1'b1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_tail <= r_tail + QW'(i_push_n);
            r_head <= r_head + QW'(i_pop);
            r_cnt  <= r_cnt + (QW+1)'(i_push_n) - (QW+1)'(i_pop);
        end
    end

endmodule

// File: dv/source_text_tokenizer_checker.sv
// token checker for source_text_tokenizer_core: watches both channels, predicts
// the token stream of every accepted word and compares each output word
// depends on stt_pkg
module source_text_tokenizer_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  logic           i_op,
    input  logic [7:0]     i_ch,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  stt_pkg::t_kind i_kind,
    input  logic [31:0]    i_offset,
    input  logic [31:0]    i_span_len,
    input  logic           i_last,
    output int             o_errors,
    output int             o_pending,
    output int             o_tokens
);
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam int WORD_MAX = 10;

    localparam logic [5:0] LM_IDLE    = 6'd0;
    localparam logic [5:0] LM_IDENT   = 6'd1;
    localparam logic [5:0] LM_NZERO   = 6'd2;
    localparam logic [5:0] LM_NINT    = 6'd3;
    localparam logic [5:0] LM_NFRAC   = 6'd4;
    localparam logic [5:0] LM_NEXP0   = 6'd5;
    localparam logic [5:0] LM_NEXP    = 6'd6;
    localparam logic [5:0] LM_NHEX    = 6'd7;
    localparam logic [5:0] LM_STR     = 6'd8;
    localparam logic [5:0] LM_STR_ESC = 6'd9;
    localparam logic [5:0] LM_CHR     = 6'd10;
    localparam logic [5:0] LM_CHR_ESC = 6'd11;
    localparam logic [5:0] LM_OPS     = 6'd12;
    localparam logic [5:0] LM_COLON   = 6'd12;
    localparam logic [5:0] LM_LT      = 6'd13;
    localparam logic [5:0] LM_SHL     = 6'd14;
    localparam logic [5:0] LM_GT      = 6'd15;
    localparam logic [5:0] LM_SHR     = 6'd16;
    localparam logic [5:0] LM_BANG    = 6'd17;
    localparam logic [5:0] LM_TILDE   = 6'd21;
    localparam logic [5:0] LM_PLUS    = 6'd25;
    localparam logic [5:0] LM_MINUS   = 6'd26;
    localparam logic [5:0] LM_STAR    = 6'd27;
    localparam logic [5:0] LM_SLASH   = 6'd28;
    localparam logic [5:0] LM_PERCENT = 6'd29;
    localparam logic [5:0] LM_CARET   = 6'd30;
    localparam logic [5:0] LM_AMP     = 6'd31;
    localparam logic [5:0] LM_AMP2    = 6'd32;
    localparam logic [5:0] LM_PIPE    = 6'd33;
    localparam logic [5:0] LM_PIPE2   = 6'd34;

    localparam t_kind NO_KIND = 7'd127;

    // kind when the operator stops here, and kind when '=' completes it
    localparam t_kind OP_STOP [23] = '{
        7'd40, 7'd44, 7'd43, 7'd48, 7'd47, 7'd56, 7'd51, 7'd53, 7'd55, 7'd64, 7'd59,
        7'd61, 7'd63, 7'd66, 7'd68, 7'd70, 7'd72, 7'd74, 7'd84, 7'd78, 7'd76, 7'd82,
        7'd80
    };
    localparam t_kind OP_EQ [23] = '{
        NO_KIND, 7'd41, 7'd42, 7'd45, 7'd46, 7'd49, 7'd50, 7'd52, 7'd54, 7'd57, 7'd58,
        7'd60, 7'd62, 7'd65, 7'd67, 7'd69, 7'd71, 7'd73, 7'd83, 7'd77, 7'd75, 7'd81,
        7'd79
    };

    logic [5:0]  lex_state;
    logic [31:0] tok_start;
    logic [31:0] src_pos;
    logic [7:0]  ident_text [WORD_MAX];

    t_tok tok_expected [$];
    t_tok step_toks [2];
    int   step_count;

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_hexd(logic [7:0] c);
        return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic t_kind keyword_kind(logic [31:0] len, logic [7:0] txt [WORD_MAX]);
        logic [8*WORD_MAX-1:0] w;
        t_kind k;
        w = '0;
        k = K_IDENT;
        if (len == 0 || len > WORD_MAX) return K_IDENT;
        for (int i = 0; i < int'(len); i++) w = {w[8*WORD_MAX-9:0], txt[i]};
        // identifier bytes are never zero, so the packed value fixes the length
        case (w)
            "module":     k = 7'd0;
            "include":    k = 7'd1;
            "fn":         k = 7'd2;
            "constraint": k = 7'd3;
            "return":     k = 7'd4;
            "struct":     k = 7'd5;
            "union":      k = 7'd6;
            "defer":      k = 7'd7;
            "match":      k = 7'd8;
            "enum":       k = 7'd9;
            "type":       k = 7'd10;
            "mut":        k = 7'd11;
            "if":         k = 7'd12;
            "else":       k = 7'd13;
            "for":        k = 7'd14;
            "while":      k = 7'd15;
            "break":      k = 7'd16;
            "continue":   k = 7'd17;
            "true":       k = 7'd18;
            "false":      k = 7'd19;
            "null":       k = 7'd20;
            default:      k = K_IDENT;
        endcase
        return k;
    endfunction

    function automatic t_kind open_kind(logic [5:0] st, logic [31:0] len,
                                        logic [7:0] txt [WORD_MAX]);
        if (st == LM_IDENT) return keyword_kind(len, txt);
        if (st >= LM_NZERO && st <= LM_NHEX) return K_NUMBER;
        if (st == LM_STR || st == LM_STR_ESC) return K_STRING;
        if (st == LM_CHR || st == LM_CHR_ESC) return K_CHAR;
        return OP_STOP[st - LM_OPS];
    endfunction

    task automatic add_tok(t_kind k, logic [31:0] off, logic [31:0] len);
        step_toks[step_count] = '{kind: k, offset: off, span_len: len, last: 1'b0};
        step_count++;
    endtask

    task automatic close_with(t_kind k);
        add_tok(k, tok_start, src_pos - tok_start + 32'd1);
        lex_state = LM_IDLE;
    endtask

    // returns 1 when the byte joined the token in progress
    task automatic grow_token(logic [7:0] c, output bit took);
        bit dg, ex;
        logic [31:0] len;
        dg = is_dig(c) || c == "_";
        ex = c == "e" || c == "E";
        len = src_pos - tok_start;
        took = 1'b1;
        case (lex_state)
            LM_IDLE: begin
                took = 1'b0;
                return;
            end
            LM_IDENT: begin
                if (is_alpha(c) || is_dig(c)) begin
                    if (len < WORD_MAX) ident_text[len] = c;
                    return;
                end
            end
            LM_NZERO, LM_NINT: begin
                if (lex_state == LM_NZERO && (c == "x" || c == "X" || c == "b" ||
                    c == "B" || c == "o" || c == "O")) begin
                    lex_state = LM_NHEX;
                    return;
                end
                if (dg) begin lex_state = LM_NINT; return; end
                if (c == ".") begin lex_state = LM_NFRAC; return; end
                if (ex) begin lex_state = LM_NEXP0; return; end
            end
            LM_NFRAC: begin
                if (dg) return;
                if (ex) begin lex_state = LM_NEXP0; return; end
            end
            LM_NEXP0: begin
                if (dg || c == "+" || c == "-") begin lex_state = LM_NEXP; return; end
            end
            LM_NEXP: if (dg) return;
            LM_NHEX: if (is_hexd(c) || c == "_") return;
            LM_STR: begin
                if (c == "\"") close_with(K_STRING);
                else if (c == "\\") lex_state = LM_STR_ESC;
                return;
            end
            LM_STR_ESC: begin lex_state = LM_STR; return; end
            LM_CHR: begin
                if (c == "'") close_with(K_CHAR);
                else if (c == "\\") lex_state = LM_CHR_ESC;
                return;
            end
            LM_CHR_ESC: begin lex_state = LM_CHR; return; end
            default: begin
                if (c == "=" && OP_EQ[lex_state - LM_OPS] != NO_KIND) begin
                    close_with(OP_EQ[lex_state - LM_OPS]);
                    return;
                end
                if (lex_state == LM_COLON && c == ":") begin close_with(K_DCOLON); return; end
                if (lex_state == LM_LT && c == "<") begin lex_state = LM_SHL; return; end
                if (lex_state == LM_GT && c == ">") begin lex_state = LM_SHR; return; end
                if (lex_state == LM_BANG || lex_state == LM_TILDE) begin
                    if (c == "&") begin lex_state = lex_state + 6'd1; return; end
                    if (c == "|") begin lex_state = lex_state + 6'd2; return; end
                    if (c == "^") begin lex_state = lex_state + 6'd3; return; end
                end
                if (lex_state == LM_AMP && c == "&") begin lex_state = LM_AMP2; return; end
                if (lex_state == LM_PIPE && c == "|") begin lex_state = LM_PIPE2; return; end
            end
        endcase
        add_tok(open_kind(lex_state, len, ident_text), tok_start, len);
        lex_state = LM_IDLE;
        took = 1'b0;
    endtask

    task automatic open_token(logic [7:0] c);
        logic [5:0] st;
        t_kind one;
        st = LM_IDLE;
        one = NO_KIND;
        if (c == " " || c == "\t" || c == "\n" || c == "\r") return;
        tok_start = src_pos;
        if (is_dig(c)) st = (c == "0") ? LM_NZERO : LM_NINT;
        else if (is_alpha(c)) begin
            ident_text[0] = c;
            st = LM_IDENT;
        end else begin
            case (c)
                "(": one = K_LPAREN;
                ")": one = K_RPAREN;
                "{": one = K_LBRACE;
                "}": one = K_RBRACE;
                "[": one = K_LBRACK;
                "]": one = K_RBRACK;
                ";": one = K_SEMI;
                ".": one = K_DOT;
                ",": one = K_COMMA;
                "#": one = K_HASH;
                "$": one = K_DOLLAR;
                "@": one = K_AT;
                "?": one = K_QUEST;
                "'": st = LM_CHR;
                "\"": st = LM_STR;
                ":": st = LM_COLON;
                "<": st = LM_LT;
                ">": st = LM_GT;
                "!": st = LM_BANG;
                "~": st = LM_TILDE;
                "+": st = LM_PLUS;
                "-": st = LM_MINUS;
                "*": st = LM_STAR;
                "/": st = LM_SLASH;
                "%": st = LM_PERCENT;
                "&": st = LM_AMP;
                "|": st = LM_PIPE;
                "^": st = LM_CARET;
                default: one = K_ERROR;
            endcase
        end
        if (one != NO_KIND) add_tok(one, src_pos, 32'd1);
        else lex_state = st;
    endtask

    task automatic predict_word(logic op, logic [7:0] c);
        bit took;
        step_count = 0;
        if (op) begin
            if (lex_state != LM_IDLE) begin
                add_tok(open_kind(lex_state, src_pos - tok_start, ident_text), tok_start,
                        src_pos - tok_start);
                lex_state = LM_IDLE;
            end
            add_tok(K_END, src_pos, 32'd0);
        end else begin
            grow_token(c, took);
            if (!took) open_token(c);
            src_pos = src_pos + 32'd1;
        end
        if (step_count > 0) step_toks[step_count - 1].last = 1'b1;
        for (int i = 0; i < step_count; i++) tok_expected.push_back(step_toks[i]);
    endtask

    task automatic report_mismatch(string what);
        o_errors++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        t_tok want;
        if (!i_rst_n) begin
            lex_state = LM_IDLE;
            tok_start = '0;
            src_pos = '0;
            for (int i = 0; i < WORD_MAX; i++) ident_text[i] = '0;
            tok_expected.delete();
        end else begin
            if (i_in_valid && !i_in_stall) predict_word(i_op, i_ch);
            if (i_out_valid && !i_out_stall) begin
                o_tokens++;
                if (tok_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected token kind %0d at %0d",
                                              i_kind, i_offset));
                end else begin
                    want = tok_expected.pop_front();
                    if (i_kind !== want.kind || i_offset !== want.offset ||
                        i_span_len !== want.span_len || i_last !== want.last) begin
                        report_mismatch($sformatf(
                            "got kind %0d off %0d len %0d last %0b, want %0d %0d %0d %0b",
                            i_kind, i_offset, i_span_len, i_last,
                            want.kind, want.offset, want.span_len, want.last));
                    end
                end
            end
        end
        o_pending = tok_expected.size();
    end

endmodule

// File: dv/source_text_tokenizer_core_tb.sv
// testbench top for source_text_tokenizer_core: clock, reset, source text stimulus
// and output stall control; depends on stt_pkg and source_text_tokenizer_checker
module source_text_tokenizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_op;
    logic [7:0]  i_ch;
    logic        o_valid;
    logic        i_stall;
    t_kind       o_kind;
    logic [31:0] o_offset;
    logic [31:0] o_span_len;
    logic        o_last;

    int errors, pending, tokens_seen;
    int send_idle_pct, stall_pct;
    bit hold_req;
    int words_sent;

    logic [8:0] src_words [$];

    string keywords [21] = '{
        "module", "include", "fn", "constraint", "return", "struct", "union",
        "defer", "match", "enum", "type", "mut", "if", "else", "for", "while",
        "break", "continue", "true", "false", "null"
    };
    string operators [] = '{
        "::", ":", "<=", "<<=", "<<", "<", ">=", ">>=", ">>", ">", "!=", "!&=", "!&",
        "!|=", "!|", "!^=", "!^", "!", "~=", "~&=", "~&", "~|=", "~|", "~^=", "~^",
        "~", "+=", "+", "-=", "-", "*=", "*", "/=", "/", "%=", "%", "&&=", "&&",
        "&=", "&", "||=", "||", "|=", "|", "^=", "^", "(", ")", "{", "}", "[", "]",
        ";", ".", ",", "#", "$", "@", "?"
    };

    source_text_tokenizer_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_op(i_op), .i_ch(i_ch), .o_valid(o_valid), .i_stall(i_stall),
        .o_kind(o_kind), .o_offset(o_offset), .o_span_len(o_span_len), .o_last(o_last)
    );

    source_text_tokenizer_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_op(i_op), .i_ch(i_ch), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_kind(o_kind), .i_offset(o_offset), .i_span_len(o_span_len), .i_last(o_last),
        .o_errors(errors), .o_pending(pending), .o_tokens(tokens_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("timeout");
        $display("TB_ERROR");
        $finish;
    end

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) src_words.push_back({1'b0, s[i]});
    endtask

    task automatic push_eos();
        src_words.push_back({1'b1, 8'($urandom_range(255))});
    endtask

    function automatic string rand_from(string pool, int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(pool[$urandom_range(pool.len() - 1)])};
        return s;
    endfunction

    // one random lexeme, mostly well formed, sometimes noise
    task automatic push_lexeme();
        string alnum, s;
        int pick;
        alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        pick = $urandom_range(99);
        if (pick < 15) begin
            s = keywords[$urandom_range(20)];
            if ($urandom_range(5) == 0) s = {s, rand_from(alnum, $urandom_range(1, 3))};
        end else if (pick < 30) begin
            s = {rand_from("abcxyzQ_", 1), rand_from(alnum, $urandom_range(0, 13))};
        end else if (pick < 45) begin
            case ($urandom_range(3))
                0: s = {"0", rand_from("xXbBoO", 1), rand_from("0123456789abcdefABCDEF_",
                        $urandom_range(0, 5))};
                1: s = {rand_from("0123456789", 1), rand_from("0123456789_",
                        $urandom_range(0, 4))};
                2: s = {rand_from("123", 1), ".", rand_from("0123456789_",
                        $urandom_range(0, 3))};
                default: s = {rand_from("0123456789", $urandom_range(1, 3)),
                        rand_from(".", $urandom_range(0, 1)), rand_from("eE", 1),
                        rand_from("+-0123456789", $urandom_range(0, 1)),
                        rand_from("0123456789_", $urandom_range(0, 3))};
            endcase
        end else if (pick < 55) begin
            s = {"\"", rand_from("ab \\\"'x=", $urandom_range(0, 6)), "\""};
        end else if (pick < 62) begin
            s = {"'", rand_from("a\\'n", $urandom_range(0, 3)), "'"};
        end else if (pick < 85) begin
            s = operators[$urandom_range(operators.size() - 1)];
        end else if (pick < 93) begin
            s = rand_from(" \t\n\r", $urandom_range(1, 3));
        end else if (pick < 98) begin
            src_words.push_back({1'b0, 8'($urandom_range(255))});
            return;
        end else begin
            push_eos();
            return;
        end
        push_text(s);
        if ($urandom_range(3) != 0) push_text(" ");
    endtask

    // send everything queued, honoring o_stall; valid stays high between words unless a random idle gap is drawn
    task automatic drive_words();
        bit taken;
        while (src_words.size() > 0) begin
            if ($urandom_range(99) < send_idle_pct) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            {i_op, i_ch} <= src_words.pop_front();
            i_valid <= 1'b1;
            taken = 1'b0;
            while (!taken) begin
                @(negedge i_clk);
                taken = !o_stall;
                @(posedge i_clk);
            end
            words_sent++;
        end
        i_valid <= 1'b0;
    endtask

    task automatic drain_tokens();
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // one long hold-off of the receiver once it is requested
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_done = 1'b1;
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial begin
        int idle_set [4] = '{0, 58, 0, 28};
        int stall_set [4] = '{0, 0, 58, 28};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = 1'b0;
        i_ch = 8'd0;
        hold_req = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        words_sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bare prefix and fraction, greedy operators, bad bytes, a long
        // non-keyword, then an unterminated string ending in a backslash
        push_text("0x 1. 1e+ ~^=!&");
        src_words.push_back({1'b0, 8'hff});
        src_words.push_back({1'b0, 8'h00});
        push_text("constraintz null \"a\\");
        push_eos();
        push_eos();
        drive_words();
        drain_tokens();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_set[ph];
            stall_pct = stall_set[ph];
            while (src_words.size() < 480) push_lexeme();
            push_eos();
            // long receiver hold-off while words keep coming
            if (ph == 0) hold_req = 1'b1;
            drive_words();
            drain_tokens();
        end
        stall_pct = 0;
        drain_tokens();

        $display("sent %0d source words, checked %0d tokens across four stall/idle mixes",
                 words_sent, tokens_seen);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
